// File: design/proximity_trigger_qualifier_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the proximity trigger qualifier modules.
// They sample on clk and are disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef PROXIMITY_TRIGGER_QUALIFIER_TOP_ASSERT_SVH
`define PROXIMITY_TRIGGER_QUALIFIER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PTQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/ptq_pkg.sv
// ---------------------------------------------------------------------------
// ptq_pkg
// Types, register indexes and reset values shared by the qualifier modules.
// ---------------------------------------------------------------------------
`default_nettype none

package ptq_pkg;

    localparam int CfgIndexWidth = 3;
    localparam int CfgDataWidth  = 16;

    // Configuration register indexes.
    localparam logic [CfgIndexWidth-1:0] REG_SENSOR_PRESENT = 3'd0;
    localparam logic [CfgIndexWidth-1:0] REG_NEAR_THRESHOLD = 3'd1;
    localparam logic [CfgIndexWidth-1:0] REG_RELEASE_THRESH = 3'd2;
    localparam logic [CfgIndexWidth-1:0] REG_REQUIRED_HITS  = 3'd3;
    localparam logic [CfgIndexWidth-1:0] REG_COOLDOWN       = 3'd4;
    localparam logic [CfgIndexWidth-1:0] REG_SERVICE_PERIOD = 3'd5;

    // Item action codes.
    localparam logic ACT_SERVICE = 1'b0;
    localparam logic ACT_CLEAR   = 1'b1;

    // Register reset values.
    localparam logic        RST_SENSOR_PRESENT = 1'b1;
    localparam logic [15:0] RST_NEAR_THRESHOLD = 16'd180;
    localparam logic [15:0] RST_RELEASE_THRESH = 16'd220;
    localparam logic [3:0]  RST_REQUIRED_HITS  = 4'd2;
    localparam logic [15:0] RST_COOLDOWN       = 16'd450;
    localparam logic [7:0]  RST_SERVICE_PERIOD = 8'd5;

    typedef struct packed {
        logic        sensor_present;
        logic [15:0] near_threshold_mm;
        logic [15:0] release_threshold_mm;
        logic [3:0]  required_hits;
        logic [15:0] cooldown_ms;
        logic [7:0]  service_period_ms;
    } ptq_cfg_t;

    typedef struct packed {
        logic        action;
        logic [31:0] now_ms;
        logic        read_ok;
        logic [15:0] distance_mm;
        logic        auto_enabled;
        logic        armed;
        logic        fault_latched;
        logic        stall_seen;
    } ptq_item_t;

    typedef struct packed {
        logic        fire;
        logic        sample_taken;
        logic [3:0]  hit_count;
        logic        latch_state;
        logic [15:0] stored_distance_mm;
        logic        has_sample;
    } ptq_result_t;

endpackage

`default_nettype wire

// File: design/ptq_cfg_regs.sv
// ---------------------------------------------------------------------------
// ptq_cfg_regs
// Configuration register file; one write per cycle, always ready.
// ---------------------------------------------------------------------------
`default_nettype none

module ptq_cfg_regs
    import ptq_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_valid,
    input  wire logic [CfgIndexWidth-1:0] cfg_index,
    input  wire logic [CfgDataWidth-1:0]  cfg_data,
    output ptq_cfg_t                      cfg
);

    ptq_cfg_t cfg_reg;
    ptq_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SENSOR_PRESENT: cfg_next.sensor_present       = cfg_data[0];
                REG_NEAR_THRESHOLD: cfg_next.near_threshold_mm    = cfg_data;
                REG_RELEASE_THRESH: cfg_next.release_threshold_mm = cfg_data;
                REG_REQUIRED_HITS:  cfg_next.required_hits        = cfg_data[3:0];
                REG_COOLDOWN:       cfg_next.cooldown_ms          = cfg_data;
                REG_SERVICE_PERIOD: cfg_next.service_period_ms    = cfg_data[7:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sensor_present       <= RST_SENSOR_PRESENT;
            cfg_reg.near_threshold_mm    <= RST_NEAR_THRESHOLD;
            cfg_reg.release_threshold_mm <= RST_RELEASE_THRESH;
            cfg_reg.required_hits        <= RST_REQUIRED_HITS;
            cfg_reg.cooldown_ms          <= RST_COOLDOWN;
            cfg_reg.service_period_ms    <= RST_SERVICE_PERIOD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: design/ptq_core.sv
// ---------------------------------------------------------------------------
// ptq_core
// Qualifier state and its update for one item; the state loads when step_en is high.
// ---------------------------------------------------------------------------
`default_nettype none

module ptq_core
    import ptq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      step_en,
    input  wire ptq_cfg_t  cfg,
    input  wire ptq_item_t item,
    output ptq_result_t    result
);

`include "proximity_trigger_qualifier_top_assert.svh"

    logic [31:0] last_service_reg;
    logic [31:0] last_service_next;
    logic [3:0]  hits_reg;
    logic [3:0]  hits_next;
    logic        latch_reg;
    logic        latch_next;
    logic [31:0] cool_until_reg;
    logic [31:0] cool_until_next;
    logic [15:0] last_dist_reg;
    logic [15:0] last_dist_next;
    logic        sample_valid_reg;
    logic        sample_valid_next;

    logic [31:0] since_service;
    logic [31:0] since_cool;
    logic        service_due;
    logic        cool_done;
    logic [3:0]  hits_inc;
    logic        fire;
    logic        taken;

    always_comb
    begin
        since_service = item.now_ms - last_service_reg;
        since_cool    = item.now_ms - cool_until_reg;
        service_due   = since_service >= {24'd0, cfg.service_period_ms};
        cool_done     = !since_cool[31];
        // Hits stop at the required count; a count already above it is kept.
        hits_inc      = (hits_reg < cfg.required_hits) ? hits_reg + 4'd1 : hits_reg;

        last_service_next = last_service_reg;
        hits_next         = hits_reg;
        latch_next        = latch_reg;
        cool_until_next   = cool_until_reg;
        last_dist_next    = last_dist_reg;
        sample_valid_next = sample_valid_reg;
        fire              = 1'b0;
        taken             = 1'b0;

        if (item.action == ACT_CLEAR)
        begin
            latch_next = 1'b0;
            hits_next  = 4'd0;
        end
        else if (cfg.sensor_present && service_due)
        begin
            last_service_next = item.now_ms;
            if (item.read_ok)
            begin
                last_dist_next    = item.distance_mm;
                sample_valid_next = 1'b1;
                taken             = 1'b1;
                if (item.distance_mm >= cfg.release_threshold_mm)
                begin
                    latch_next = 1'b0;
                    hits_next  = 4'd0;
                end
                else if (item.distance_mm == 16'd0 ||
                         item.distance_mm > cfg.near_threshold_mm)
                begin
                    hits_next = 4'd0;
                end
                else
                begin
                    hits_next = hits_inc;
                    if (!latch_reg && hits_inc >= cfg.required_hits &&
                        item.auto_enabled && item.armed && !item.fault_latched &&
                        !item.stall_seen && cool_done)
                    begin
                        fire            = 1'b1;
                        latch_next      = 1'b1;
                        cool_until_next = item.now_ms + {16'd0, cfg.cooldown_ms};
                    end
                end
            end
        end

        result.fire               = fire;
        result.sample_taken       = taken;
        result.hit_count          = hits_next;
        result.latch_state        = latch_next;
        result.stored_distance_mm = last_dist_next;
        result.has_sample         = sample_valid_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_service_reg <= '0;
            hits_reg         <= '0;
            latch_reg        <= 1'b0;
            cool_until_reg   <= '0;
            last_dist_reg    <= '0;
            sample_valid_reg <= 1'b0;
        end
        else if (step_en)
        begin
            last_service_reg <= last_service_next;
            hits_reg         <= hits_next;
            latch_reg        <= latch_next;
            cool_until_reg   <= cool_until_next;
            last_dist_reg    <= last_dist_next;
            sample_valid_reg <= sample_valid_next;
        end
    end

    // A trigger sets the latch, which then blocks further triggers.
    `PTQ_ASSERT_NEXT(a_fire_sets_latch, step_en && fire, latch_reg, "fire did not set latch")
    // A clear item always leaves latch and hits empty.
    `PTQ_ASSERT_NEXT(a_clear_empties, step_en && item.action == ACT_CLEAR, hits_reg == 4'd0 && !latch_reg, "clear item left state behind")
    // With the sensor absent a service item must not move the service time.
    `PTQ_ASSERT_NEXT(a_absent_holds, step_en && item.action == ACT_SERVICE && !cfg.sensor_present, $stable(last_service_reg) && $stable(last_dist_reg), "absent sensor changed state")

endmodule

`default_nettype wire

// File: design/proximity_trigger_qualifier_top.sv
// ---------------------------------------------------------------------------
// proximity_trigger_qualifier_top
// Turns a stream of range samples into debounced, latched trigger pulses.
// ---------------------------------------------------------------------------
//
//  Channel  Handshake                Payload
//  -------  -----------------------  ------------------------------------------
//  in       in_valid / in_stall      action, now_ms, read_ok, distance_mm,
//                                    auto_enabled, armed, fault_latched, stall_seen
//  out      out_valid / out_stall    fire, sample_taken, hit_count, latch_state,
//                                    stored_distance_mm, has_sample
//  cfg      cfg_valid / cfg_ready    cfg_index, cfg_data
//
// Each item is held in the input register and, once the output register can
// load, moves on to it; the block takes one item per cycle while out_stall is
// low. The qualifier state is updated in the same cycle the result is
// registered, so the next item sees it immediately.
// Reset (rst_n, asynchronous) empties both registers and clears the state.
// A stalled output holds its item; the input register still takes one more
// item, after which in_stall rises until the output moves.
// ---------------------------------------------------------------------------
`default_nettype none

module proximity_trigger_qualifier_top
    import ptq_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,

    input  wire logic                     in_valid,
    output      logic                     in_stall,
    input  wire logic                     action,
    input  wire logic [31:0]              now_ms,
    input  wire logic                     read_ok,
    input  wire logic [15:0]              distance_mm,
    input  wire logic                     auto_enabled,
    input  wire logic                     armed,
    input  wire logic                     fault_latched,
    input  wire logic                     stall_seen,

    output      logic                     out_valid,
    input  wire logic                     out_stall,
    output      logic                     fire,
    output      logic                     sample_taken,
    output      logic [3:0]               hit_count,
    output      logic                     latch_state,
    output      logic [15:0]              stored_distance_mm,
    output      logic                     has_sample,

    input  wire logic                     cfg_valid,
    output      logic                     cfg_ready,
    input  wire logic [CfgIndexWidth-1:0] cfg_index,
    input  wire logic [CfgDataWidth-1:0]  cfg_data
);

`include "proximity_trigger_qualifier_top_assert.svh"

    ptq_cfg_t    cfg;
    ptq_item_t   in_item;
    ptq_item_t   in_item_reg;
    logic        in_valid_reg;
    ptq_result_t step_result;
    ptq_result_t out_result_reg;
    logic        out_valid_reg;
    logic        out_load;
    logic        in_load;
    logic        step_en;

    // The output register can take a result when it is empty or draining.
    // The input register can take an item when it is empty or passing its
    // item on in this cycle.
    assign out_load = !out_valid_reg || !out_stall;
    assign in_load  = !in_valid_reg || out_load;
    assign step_en  = in_valid_reg && out_load;
    assign in_stall = !in_load;

    // Configuration writes are taken in every cycle.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        in_item.action        = action;
        in_item.now_ms        = now_ms;
        in_item.read_ok       = read_ok;
        in_item.distance_mm   = distance_mm;
        in_item.auto_enabled  = auto_enabled;
        in_item.armed         = armed;
        in_item.fault_latched = fault_latched;
        in_item.stall_seen    = stall_seen;
    end

    ptq_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ptq_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .cfg     (cfg),
        .item    (in_item_reg),
        .result  (step_result)
    );

    // Input register: valid bit is reset, payload is not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_load)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load && in_valid)
        begin
            in_item_reg <= in_item;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            out_result_reg <= step_result;
        end
    end

    assign out_valid          = out_valid_reg;
    assign fire               = out_result_reg.fire;
    assign sample_taken       = out_result_reg.sample_taken;
    assign hit_count          = out_result_reg.hit_count;
    assign latch_state        = out_result_reg.latch_state;
    assign stored_distance_mm = out_result_reg.stored_distance_mm;
    assign has_sample         = out_result_reg.has_sample;

    // A waiting item is never dropped while the output is blocked.
    `PTQ_ASSERT_NEXT(a_item_held, in_valid_reg && !out_load, in_valid_reg && $stable(in_item_reg), "waiting item lost")
    // An item handed to the core always shows up on the output.
    `PTQ_ASSERT_NEXT(a_item_moves, step_en, out_valid_reg, "processed item missing from output")
    // With the output blocked, input stalls exactly when the input register is full.
    `PTQ_ASSERT_SAME(a_stall_when_full, out_valid_reg && out_stall, in_stall == in_valid_reg, "input stall wrong while output blocked")

endmodule

`default_nettype wire
